/* hw/rtl/nfsa_pkg.sv */
package nfsa_pkg;

    localparam int MAX_SLOTS  = 64;
    localparam int ADDR_WIDTH = 32;

    localparam int IDX_W  = $clog2(MAX_SLOTS);
    localparam int CNT_W  = $clog2(MAX_SLOTS + 1);
    localparam int SB_W   = 16;
    localparam int SIU_W  = 7;
    localparam int SPAN_W = SB_W + CNT_W;
    localparam int CMP_W  = (ADDR_WIDTH > SPAN_W) ? ADDR_WIDTH : SPAN_W;
    localparam int REG_W  = 2;

    typedef enum logic [REG_W-1:0] {
        REG_BASE_ADDRESS = 2'd0,
        REG_SLOT_BYTES   = 2'd1,
        REG_SLOTS_IN_USE = 2'd2
    } t_reg_idx;

    typedef enum logic {
        CMD_ALLOC = 1'b0,
        CMD_FREE  = 1'b1
    } t_cmd;

    typedef enum logic [1:0] {
        ALU_ADD = 2'd0,
        ALU_SUB = 2'd1,
        ALU_MUL = 2'd2
    } t_alu_op;

    typedef struct packed {
        logic [ADDR_WIDTH-1:0] base_address;
        logic [SB_W-1:0]       slot_bytes;
        logic [SIU_W-1:0]      slots_in_use;
    } t_cfg;

    typedef struct packed {
        t_alu_op          op;
        logic [CMP_W-1:0] a;
        logic [CMP_W-1:0] b;
        logic [CMP_W-1:0] c;
    } t_alu_req;

    typedef struct packed {
        logic [CMP_W-1:0] res;
        logic             eq;
        logic             lt;
    } t_alu_rsp;

endpackage

/* hw/rtl/nfsa_ifs.sv */
interface nfsa_req_if;
    logic                             valid;
    logic                             ready;
    nfsa_pkg::t_cmd                   cmd;
    logic [nfsa_pkg::ADDR_WIDTH-1:0]  free_address;

    modport source (output valid, cmd, free_address, input ready);
    modport sink   (input valid, cmd, free_address, output ready);
endinterface

interface nfsa_rsp_if;
    logic                             valid;
    logic                             ready;
    logic                             ok;
    logic [nfsa_pkg::ADDR_WIDTH-1:0]  slot_address;

    modport source (output valid, ok, slot_address, input ready);
    modport sink   (input valid, ok, slot_address, output ready);
endinterface

interface nfsa_cfg_if;
    logic                             valid;
    logic                             ready;
    logic [nfsa_pkg::REG_W-1:0]       index;
    logic [nfsa_pkg::ADDR_WIDTH-1:0]  data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

/* hw/rtl/nfsa_cfg_regs.sv */
module nfsa_cfg_regs (
    input  logic           i_clk,
    input  logic           i_rst_n,
    nfsa_cfg_if.sink       i_cfg,
    output nfsa_pkg::t_cfg o_cfg
);
    import nfsa_pkg::*;

    t_cfg r_cfg;

    assign i_cfg.ready = 1'b1;
    assign o_cfg       = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.base_address <= '0;
            r_cfg.slot_bytes   <= SB_W'(1);
            r_cfg.slots_in_use <= SIU_W'(64);
        end else if (i_cfg.valid) begin
            case (t_reg_idx'(i_cfg.index))
                REG_BASE_ADDRESS: r_cfg.base_address <= i_cfg.data;
                REG_SLOT_BYTES:   r_cfg.slot_bytes   <= i_cfg.data[SB_W-1:0];
                REG_SLOTS_IN_USE: r_cfg.slots_in_use <= i_cfg.data[SIU_W-1:0];
                default: begin
                end
            endcase
        end
    end

endmodule

/* hw/rtl/nfsa_alu.sv */
module nfsa_alu (
    input  nfsa_pkg::t_alu_req i_req,
    output nfsa_pkg::t_alu_rsp o_rsp
);
    import nfsa_pkg::*;

    logic [IDX_W+SB_W-1:0] prod;

    assign prod = i_req.a[IDX_W-1:0] * i_req.b[SB_W-1:0];

    always_comb begin
        case (i_req.op)
            ALU_ADD: o_rsp.res = i_req.a + i_req.b;
            ALU_SUB: o_rsp.res = i_req.a - i_req.b;
            ALU_MUL: o_rsp.res = CMP_W'(prod);
            default: o_rsp.res = '0;
        endcase
        o_rsp.eq = (i_req.a == i_req.c);
        o_rsp.lt = (i_req.a < i_req.c);
    end

endmodule

/* hw/rtl/nfsa_seq.sv */
module nfsa_seq (
    input  logic               i_clk,
    input  logic               i_rst_n,
    nfsa_req_if.sink           i_req,
    nfsa_rsp_if.source         o_rsp,
    input  nfsa_pkg::t_cfg     i_cfg,
    output nfsa_pkg::t_alu_req o_alu,
    input  nfsa_pkg::t_alu_rsp i_alu
);
    import nfsa_pkg::*;

    localparam int N_W = (SIU_W > CNT_W) ? SIU_W : CNT_W;

    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_SCAN  = 7'b0000010,
        S_MUL   = 7'b0000100,
        S_ADD   = 7'b0001000,
        S_OFFS  = 7'b0010000,
        S_FSCAN = 7'b0100000,
        S_DONE  = 7'b1000000
    } t_state;

    t_state                r_state,    n_state;
    logic [MAX_SLOTS-1:0]  r_occ,      n_occ;
    logic [IDX_W-1:0]      r_next,     n_next;
    logic [IDX_W-1:0]      r_pos,      n_pos;
    logic [CNT_W-1:0]      r_k,        n_k;
    logic [CNT_W-1:0]      r_cnt,      n_cnt;
    logic [CMP_W-1:0]      r_acc,      n_acc;
    logic [CMP_W-1:0]      r_off,      n_off;
    logic                  r_res_ok,   n_res_ok;
    logic [ADDR_WIDTH-1:0] r_res_addr, n_res_addr;
    logic                  r_out_valid, n_out_valid;
    logic                  r_out_ok,   n_out_ok;
    logic [ADDR_WIDTH-1:0] r_out_addr, n_out_addr;

    logic [N_W-1:0]   siu_x;
    logic [CNT_W-1:0] cnt_eff;
    logic [CNT_W-1:0] pos_inc;
    logic [IDX_W-1:0] pos_wrap;
    logic [CNT_W-1:0] k_inc;
    logic             req_fire;

    assign siu_x    = N_W'(i_cfg.slots_in_use);
    assign cnt_eff  = (siu_x > N_W'(MAX_SLOTS)) ? CNT_W'(MAX_SLOTS) : CNT_W'(siu_x);
    assign pos_inc  = CNT_W'(r_pos) + CNT_W'(1);
    assign pos_wrap = (pos_inc == r_cnt) ? '0 : IDX_W'(pos_inc);
    assign k_inc    = r_k + CNT_W'(1);
    assign req_fire = i_req.valid && i_req.ready;

    assign i_req.ready        = (r_state == S_IDLE);
    assign o_rsp.valid        = r_out_valid;
    assign o_rsp.ok           = r_out_ok;
    assign o_rsp.slot_address = r_out_addr;

    always_comb begin
        o_alu.op = ALU_ADD;
        o_alu.a  = r_acc;
        o_alu.b  = CMP_W'(i_cfg.slot_bytes);
        o_alu.c  = r_off;
        case (r_state)
            S_OFFS: begin
                o_alu.op = ALU_SUB;
                o_alu.a  = r_off;
                o_alu.b  = CMP_W'(i_cfg.base_address);
            end
            S_MUL: begin
                o_alu.op = ALU_MUL;
                o_alu.a  = CMP_W'(r_pos);
            end
            S_ADD: begin
                o_alu.a  = CMP_W'(i_cfg.base_address);
                o_alu.b  = r_acc;
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        n_state     = r_state;
        n_occ       = r_occ;
        n_next      = r_next;
        n_pos       = r_pos;
        n_k         = r_k;
        n_cnt       = r_cnt;
        n_acc       = r_acc;
        n_off       = r_off;
        n_res_ok    = r_res_ok;
        n_res_addr  = r_res_addr;
        n_out_valid = r_out_valid && !o_rsp.ready;
        n_out_ok    = r_out_ok;
        n_out_addr  = r_out_addr;

        case (r_state)
            S_IDLE: begin
                if (req_fire) begin
                    n_cnt      = cnt_eff;
                    n_k        = '0;
                    n_res_ok   = 1'b0;
                    n_res_addr = '0;
                    if (i_req.cmd == CMD_FREE) begin
                        n_off   = CMP_W'(i_req.free_address);
                        n_state = S_OFFS;
                    end else if (cnt_eff == '0) begin
                        n_state = S_DONE;
                    end else begin
                        n_pos   = (CNT_W'(r_next) < cnt_eff) ? r_next : '0;
                        n_state = S_SCAN;
                    end
                end
            end
            S_SCAN: begin
                if (!r_occ[r_pos]) begin
                    n_occ[r_pos] = 1'b1;
                    n_next       = pos_wrap;
                    n_state      = S_MUL;
                end else if (k_inc == r_cnt) begin
                    n_state = S_DONE;
                end else begin
                    n_k   = k_inc;
                    n_pos = pos_wrap;
                end
            end
            S_MUL: begin
                n_acc   = i_alu.res;
                n_state = S_ADD;
            end
            S_ADD: begin
                n_res_ok   = 1'b1;
                n_res_addr = i_alu.res[ADDR_WIDTH-1:0];
                n_state    = S_DONE;
            end
            S_OFFS: begin
                n_off = CMP_W'(i_alu.res[ADDR_WIDTH-1:0]);
                n_acc = '0;
                if (i_cfg.slot_bytes == '0 || r_cnt == '0) begin
                    n_state = S_DONE;
                end else begin
                    n_state = S_FSCAN;
                end
            end
            S_FSCAN: begin
                if (r_k == r_cnt) begin
                    n_state = S_DONE;
                end else if (i_alu.eq) begin
                    n_occ[r_k[IDX_W-1:0]] = 1'b0;
                    n_res_ok              = 1'b1;
                    n_state               = S_DONE;
                end else if (!i_alu.lt) begin
                    n_state = S_DONE;
                end else begin
                    n_acc = i_alu.res;
                    n_k   = k_inc;
                end
            end
            S_DONE: begin
                if (!r_out_valid || o_rsp.ready) begin
                    n_out_valid = 1'b1;
                    n_out_ok    = r_res_ok;
                    n_out_addr  = r_res_addr;
                    n_state     = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_occ       <= '0;
            r_next      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_occ       <= n_occ;
            r_next      <= n_next;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pos      <= n_pos;
        r_k        <= n_k;
        r_cnt      <= n_cnt;
        r_acc      <= n_acc;
        r_off      <= n_off;
        r_res_ok   <= n_res_ok;
        r_res_addr <= n_res_addr;
        r_out_ok   <= n_out_ok;
        r_out_addr <= n_out_addr;
    end

    a_scan_in_pool: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN) |-> (CNT_W'(r_pos) < r_cnt))
        else $error("scan pointer outside the pool");

    a_claim_set: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_MUL) |-> r_occ[r_pos])
        else $error("claimed slot not marked occupied");

    a_fscan_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FSCAN) |-> (r_k <= r_cnt))
        else $error("free search ran past the pool");

    a_req_leaves_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        req_fire |=> (r_state != S_IDLE))
        else $error("accepted request left no work");

    a_rsp_from_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state == S_DONE))
        else $error("response loaded outside the done state");

endmodule

/* hw/rtl/next_fit_slot_allocator.sv */
// Channel  Dir  Payload                        Accepted when
// i_req    in   cmd, free_address              i_req.valid && i_req.ready
// o_rsp    out  ok, slot_address               o_rsp.valid && o_rsp.ready
// i_cfg    in   index, data                    i_cfg.valid && i_cfg.ready
//
// Allocate and free each run as a sequence of states from acceptance to response:
// the bitmap scan tests one slot per cycle and the free-address search
// steps one slot per cycle through the shared adder/comparator.
// Synchronous active-low reset clears the occupancy bitmap and pointer at once.
// A finished response waits in an output register; a new request is taken meanwhile.
// i_cfg is always ready.
module next_fit_slot_allocator (
    input  logic        i_clk,
    input  logic        i_rst_n,
    nfsa_req_if.sink    i_req,
    nfsa_rsp_if.source  o_rsp,
    nfsa_cfg_if.sink    i_cfg
);
    import nfsa_pkg::*;

    t_cfg     cfg;
    t_alu_req alu_req;
    t_alu_rsp alu_rsp;

    nfsa_cfg_regs u_cfg_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (i_cfg),
        .o_cfg   (cfg)
    );

    nfsa_alu u_alu (
        .i_req (alu_req),
        .o_rsp (alu_rsp)
    );

    nfsa_seq u_seq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (i_req),
        .o_rsp   (o_rsp),
        .i_cfg   (cfg),
        .o_alu   (alu_req),
        .i_alu   (alu_rsp)
    );

endmodule
